/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/tht_pkg.sv */
// ----------------------------------------------------------------------------
// tht_pkg
// Types and constants shared by the handle table modules.
// ----------------------------------------------------------------------------
package tht_pkg;

    localparam int SLOT_W    = 6;
    localparam int TAG_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int FLAGS_W   = 32;
    localparam int MODE_W    = 3;
    localparam int FIELD_SLOTS = 64;   // slots reachable by a 6-bit slot field
    localparam int GRP_W     = 8;      // slots examined per scan step
    localparam int GRP_IDX_W = 3;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 136;

    localparam logic KIND_FILE = 1'b0;
    localparam logic KIND_DIR  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_OPEN_FILE = 3'd0,
        MODE_OPEN_DIR  = 3'd1,
        MODE_GET_FILE  = 3'd2,
        MODE_GET_DIR   = 3'd3,
        MODE_CLOSE     = 3'd4,
        MODE_QUERY     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // One stored slot entry
    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic                 kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [FLAGS_W-1:0]   flags;
    } t_entry;

    // Response data, last field in the lowest bits
    typedef struct packed {
        logic [FLAGS_W-1:0]   flags;
        logic [PAYLOAD_W-1:0] payload;
        logic [TAG_W-1:0]     tag;
        logic [SLOT_W-1:0]    slot;
        t_status              status;
    } t_rsp;

    // Free-slot scan step result
    typedef struct packed {
        logic                 hit;
        logic [GRP_IDX_W-1:0] idx;
    } t_scan;

endpackage

/* src/tagged_handle_table.sv */
// ----------------------------------------------------------------------------
// tagged_handle_table
// Generational handle slot table with open, get, close and flags query.
// ----------------------------------------------------------------------------
// One operation is handled at a time. An open steps the shared scan unit
// through the eight-slot groups until it finds the lowest free slot (from 1
// up to ceil(min(TABLE_SLOTS, 64) / 8) groups; a full table costs every
// group). Get, close and flags query go through the registered read of the
// slot RAM. The result sits in an output register, so the next operation
// can be taken while it waits for tready.
// Slot occupancy lives in flip-flops cleared by reset; no clearing pass.
module tagged_handle_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: slot_index[5:0], tag_in[37:6], payload_in[101:38],
    //        flags_in[133:102], zero pad[135:134]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [tht_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [tht_pkg::MODE_W-1:0]        i_s_axis_tuser,   // mode
    // tdata: status[1:0], slot_out[7:2], tag_out[39:8],
    //        payload_out[103:40], flags_out[135:104]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [tht_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                              o_m_axis_tuser    // closed_kind
);
    import tht_pkg::*;

    localparam int LIVE   = (TABLE_SLOTS < FIELD_SLOTS) ? TABLE_SLOTS : FIELD_SLOTS;
    localparam int AW     = $clog2(LIVE);
    localparam int NGRP   = (LIVE + GRP_W - 1) / GRP_W;
    localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int ENT_W  = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_in_range, n_in_range;
    logic [TAG_W-1:0]      r_tag, n_tag;
    logic [PAYLOAD_W-1:0]  r_payload, n_payload;
    logic [FLAGS_W-1:0]    r_flags, n_flags;
    logic [GW-1:0]         r_grp, n_grp;
    logic [TAG_W-1:0]      r_next_tag, n_next_tag;
    logic [LIVE-1:0]       r_valid, n_valid;
    t_rsp                  r_res, n_res;
    logic                  r_res_kind, n_res_kind;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;
    logic                  r_out_kind, n_out_kind;

    logic [NGRP*GRP_W-1:0] free_pad;
    t_scan                 scan;
    logic [GW+GRP_IDX_W-1:0] found;
    logic [TAG_W-1:0]      issued;
    logic                  hit;
    logic                  s_fire;
    logic                  ram_we;
    t_entry                ram_wdata;
    logic [ENT_W-1:0]      ram_rdata_raw;
    t_entry                ram_rdata;
    logic [SLOT_W-1:0]     in_slot;

    assign in_slot         = i_s_axis_tdata[5:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // Occupancy as a free mask padded to whole groups (pad reads as taken)
    always_comb begin
        free_pad = '0;
        free_pad[LIVE-1:0] = ~r_valid;
    end

    tht_scan u_scan (
        .i_free (free_pad[r_grp*GRP_W +: GRP_W]),
        .o_scan (scan)
    );

    assign found  = {r_grp, scan.idx};
    assign issued = (r_next_tag == '0) ? TAG_W'(1) : r_next_tag;

    // Slot entry store: written by open, read by get, close and query
    assign ram_wdata.tag     = issued;
    assign ram_wdata.kind    = (r_mode == MODE_OPEN_DIR) ? KIND_DIR : KIND_FILE;
    assign ram_wdata.payload = r_payload;
    assign ram_wdata.flags   = (r_mode == MODE_OPEN_DIR) ? '0 : r_flags;
    assign ram_we = (r_state == S_SCAN) && scan.hit;

    tht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (LIVE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(found)),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(in_slot)),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    // Handle check against the stored tag; free slots never match
    assign hit = r_in_range && r_valid[AW'(r_slot)] && (ram_rdata.tag == r_tag);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_slot      = r_slot;
        n_in_range  = r_in_range;
        n_tag       = r_tag;
        n_payload   = r_payload;
        n_flags     = r_flags;
        n_grp       = r_grp;
        n_next_tag  = r_next_tag;
        n_valid     = r_valid;
        n_res       = r_res;
        n_res_kind  = r_res_kind;
        n_out       = r_out;
        n_out_kind  = r_out_kind;
        n_out_valid = r_out_valid && !i_m_axis_tready;

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_mode     = i_s_axis_tuser;
                    n_slot     = in_slot;
                    n_in_range = ({1'b0, in_slot} < (SLOT_W + 1)'(LIVE));
                    n_tag      = i_s_axis_tdata[37:6];
                    n_payload  = i_s_axis_tdata[101:38];
                    n_flags    = i_s_axis_tdata[133:102];
                    n_grp      = '0;
                    n_res      = '0;
                    n_res.status = ST_INVALID;
                    n_res_kind = 1'b0;
                    unique case (t_mode'(i_s_axis_tuser))
                        MODE_OPEN_FILE, MODE_OPEN_DIR: n_state = S_SCAN;
                        MODE_GET_FILE, MODE_GET_DIR,
                        MODE_CLOSE, MODE_QUERY:        n_state = S_READ;
                        default:                       n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DONE;
                unique case (t_mode'(r_mode))
                    MODE_GET_FILE: begin
                        if (hit && ram_rdata.kind == KIND_FILE) begin
                            n_res.status  = ST_OK;
                            n_res.payload = ram_rdata.payload;
                            n_res.flags   = ram_rdata.flags;
                        end
                    end
                    MODE_GET_DIR: begin
                        if (hit && ram_rdata.kind == KIND_DIR) begin
                            n_res.status  = ST_OK;
                            n_res.payload = ram_rdata.payload;
                        end
                    end
                    MODE_CLOSE: begin
                        if (hit) begin
                            n_valid[AW'(r_slot)] = 1'b0;
                            n_res.status = ST_OK;
                            n_res_kind   = ram_rdata.kind;
                        end
                    end
                    MODE_QUERY: begin
                        if (hit) begin
                            n_res.status = ST_OK;
                            n_res.flags  = ram_rdata.flags;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (scan.hit) begin
                    n_valid[AW'(found)] = 1'b1;
                    n_next_tag   = issued + TAG_W'(1);
                    n_res.status = ST_OK;
                    n_res.slot   = SLOT_W'(found);
                    n_res.tag    = issued;
                    n_state      = S_DONE;
                end else if (r_grp == GW'(NGRP - 1)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_grp = r_grp + GW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = r_res;
                    n_out_kind  = r_res_kind;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_next_tag  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_next_tag  <= n_next_tag;
            r_out_valid <= n_out_valid;
        end
    end

    // Operation and result payload
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_slot     <= n_slot;
        r_in_range <= n_in_range;
        r_tag      <= n_tag;
        r_payload  <= n_payload;
        r_flags    <= n_flags;
        r_grp      <= n_grp;
        r_res      <= n_res;
        r_res_kind <= n_res_kind;
        r_out      <= n_out;
        r_out_kind <= n_out_kind;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tuser  = r_out_kind;

endmodule

/* src/tht_ram.sv */
// ----------------------------------------------------------------------------
// tht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tht_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tht_scan.sv */
// ----------------------------------------------------------------------------
// tht_scan
// Lowest-free finder over one eight-slot group; reused every scan step.
// ----------------------------------------------------------------------------
module tht_scan (
    input  logic [tht_pkg::GRP_W-1:0] i_free,
    output tht_pkg::t_scan            o_scan
);
    import tht_pkg::*;

    // Walk from the top so the lowest free slot wins
    always_comb begin
        o_scan.hit = 1'b0;
        o_scan.idx = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (i_free[b]) begin
                o_scan.hit = 1'b1;
                o_scan.idx = GRP_IDX_W'(b);
            end
        end
    end

endmodule

/* src/tht_checker.sv */
// ----------------------------------------------------------------------------
// tht_checker
// Port-level checks on the handle table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tht_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [tht_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                          o_m_axis_tuser
);
    import tht_pkg::*;

    logic               s_fire;
    logic               out_stall;
    logic [M_TDATA_W:0] out_word;
    logic               out_fail;
    logic               out_clean;

    // Handshake and result terms used by the checks
    assign s_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word  = {o_m_axis_tuser, o_m_axis_tdata};
    assign out_fail  = o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK);
    assign out_clean = (o_m_axis_tdata[M_TDATA_W-1:2] == '0) && !o_m_axis_tuser;

    // A stalled result transaction holds its contents
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(out_word))

    // No accept right after an accept: an accepted operation leaves the idle state
    `ASSERT_NEXT(a_no_b2b, i_clk, i_rst_n, s_fire, !o_s_axis_tready)

    // A failed operation reports nothing beyond its status
    `ASSERT_IMPL(a_fail_clean, i_clk, i_rst_n, out_fail, out_clean)

endmodule

bind tagged_handle_table tht_checker u_tht_checker (.*);
